// ===== rtl/core/dlfts_pkg.sv =====
// ----------------------------------------------------------------------------
// dlfts_pkg - shared types, constants and divide helpers
// Level limits, trend codes, window sizes and the constant-divide functions
// used by the front and back parts of the level smoother.
// ----------------------------------------------------------------------------
package dlfts_pkg;

    // history and smoothing windows
    localparam int HISTORY_DEPTH = 12;
    localparam int SHORT_WINDOW  = 5;
    localparam int LONG_WINDOW   = 30;
    localparam int CONFIRM_TICKS = 15;

    // sensor limits and fusion thresholds
    localparam int LVL_MAX    = 10000;
    localparam int LVL_MIN    = -500;
    localparam int HIGH_MARK  = 1000;
    localparam int GAP_LIMIT  = 2000;
    localparam int GAP_TICKS  = 120;
    localparam int LOW_MARK   = 500;

    // trend thresholds
    localparam int RISE_LIM   = 30;
    localparam int FALL_LIM   = -1;
    localparam int STILL_LIM  = 15;
    localparam int LAG_LIM    = 300;
    localparam int BLEND_DIV  = 3;

    // trend codes
    localparam logic [2:0] TR_FALL  = 3'd0;
    localparam logic [2:0] TR_WAVE  = 3'd1;
    localparam logic [2:0] TR_LAG   = 3'd2;
    localparam logic [2:0] TR_RISE  = 3'd3;
    localparam logic [2:0] TR_STILL = 3'd4;

    // widths
    localparam int RAW_W   = 16;
    localparam int LVL_W   = 15;
    localparam int CHG_W   = RAW_W + 1;
    localparam int TR_W    = 3;
    localparam int MIS_W   = $clog2(GAP_TICKS + 2);
    localparam int HIST_TAPS = HISTORY_DEPTH - 1;
    localparam int FILL_W  = $clog2(HISTORY_DEPTH + 2);
    localparam int CNT_W   = $clog2(2 * CONFIRM_TICKS + 2);
    localparam int LAG_W   = $clog2(CONFIRM_TICKS + 1);
    localparam int WARM_W  = $clog2(LONG_WINDOW + 1);
    localparam int LONG_W  = $clog2(LONG_WINDOW * (LVL_MAX + 1)) + 1;
    localparam int SHORT_W = $clog2(SHORT_WINDOW * (LVL_MAX + 1)) + 1;
    localparam int MEAN_W  = 16;
    localparam int BLEND_W = MEAN_W + 2;
    localparam int OUT_W   = 40;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // reciprocals: q = (|x| * RCP) >> SH is exact for |x| < 2^W
    localparam int LONG_SH  = LONG_W + $clog2(LONG_WINDOW);
    localparam logic [LONG_W:0] LONG_RCP =
        (LONG_W + 1)'((64'd1 << LONG_SH) / LONG_WINDOW + 1);
    localparam int SHORT_SH = SHORT_W + $clog2(SHORT_WINDOW);
    localparam logic [SHORT_W:0] SHORT_RCP =
        (SHORT_W + 1)'((64'd1 << SHORT_SH) / SHORT_WINDOW + 1);
    localparam int BLEND_SH = BLEND_W + $clog2(BLEND_DIV);
    localparam logic [BLEND_W:0] BLEND_RCP =
        (BLEND_W + 1)'((64'd1 << BLEND_SH) / BLEND_DIV + 1);

    typedef struct packed {
        logic signed [LVL_W-1:0] fused;
        logic [TR_W-1:0]         trend;
    } dlfts_item_t;

    // signed divides, truncating toward zero
    function automatic logic signed [MEAN_W-1:0] div_long(input logic signed [LONG_W-1:0] x);
        logic [LONG_W-1:0] m;
        logic [2*LONG_W:0] p;
        logic [MEAN_W-1:0] q;
        m = x[LONG_W-1] ? LONG_W'(-x) : LONG_W'(x);
        p = m * LONG_RCP;
        q = MEAN_W'(p >> LONG_SH);
        return x[LONG_W-1] ? $signed(-q) : $signed(q);
    endfunction

    function automatic logic signed [MEAN_W-1:0] div_short(input logic signed [SHORT_W-1:0] x);
        logic [SHORT_W-1:0] m;
        logic [2*SHORT_W:0] p;
        logic [MEAN_W-1:0]  q;
        m = x[SHORT_W-1] ? SHORT_W'(-x) : SHORT_W'(x);
        p = m * SHORT_RCP;
        q = MEAN_W'(p >> SHORT_SH);
        return x[SHORT_W-1] ? $signed(-q) : $signed(q);
    endfunction

    function automatic logic signed [MEAN_W-1:0] div_blend(input logic signed [BLEND_W-1:0] x);
        logic [BLEND_W-1:0] m;
        logic [2*BLEND_W:0] p;
        logic [MEAN_W-1:0]  q;
        m = x[BLEND_W-1] ? BLEND_W'(-x) : BLEND_W'(x);
        p = m * BLEND_RCP;
        q = MEAN_W'(p >> BLEND_SH);
        return x[BLEND_W-1] ? $signed(-q) : $signed(q);
    endfunction

endpackage

// ===== rtl/core/dlfts_front.sv =====
// ----------------------------------------------------------------------------
// dlfts_front - sensor fusion and trend classification
// Validates and fuses the two heights, keeps the raw history and the trend
// confirmation counters, and pushes one request per accepted sample.
// ----------------------------------------------------------------------------
module dlfts_front
    import dlfts_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    q_ready,
    input  logic signed [RAW_W-1:0] height_a,
    input  logic signed [RAW_W-1:0] height_b,
    output logic                    push,
    output dlfts_item_t             item
);

    logic [MIS_W-1:0]  mismatch_reg, mismatch_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]  rise_reg, rise_next;
    logic [CNT_W-1:0]  fall_reg, fall_next;
    logic [CNT_W-1:0]  still_reg, still_next;
    logic [LAG_W-1:0]  lag_reg, lag_next;
    logic [TR_W-1:0]   trend_reg, trend_next;

    logic signed [RAW_W-1:0] hist_a_reg [HIST_TAPS];
    logic signed [RAW_W-1:0] hist_b_reg [HIST_TAPS];

    logic signed [LVL_W-1:0] va, vb, fa, fb, fused;
    logic signed [LVL_W:0]   gap, sum, sum_adj;
    logic                    hi, big, drop, full;
    logic signed [CHG_W-1:0] c1, c2;
    logic signed [CHG_W:0]   dc;

    assign push = in_valid && q_ready;

    // fusion
    always_comb
    begin
        va = (height_a > LVL_MAX || height_a < LVL_MIN) ? '0 : LVL_W'(height_a);
        vb = (height_b > LVL_MAX || height_b < LVL_MIN) ? '0 : LVL_W'(height_b);
        hi  = (va > HIGH_MARK) || (vb > HIGH_MARK);
        gap = (LVL_W + 1)'(va) - (LVL_W + 1)'(vb);
        big = (gap > GAP_LIMIT) || (gap < -GAP_LIMIT);
        mismatch_next = mismatch_reg;
        if (hi)
        begin
            if (big)
            begin
                if (mismatch_reg <= GAP_TICKS)
                    mismatch_next = mismatch_reg + MIS_W'(1);
            end
            else
            begin
                mismatch_next = '0;
            end
        end
        drop = hi && big && (mismatch_next > GAP_TICKS);
        fa = va;
        fb = vb;
        if (drop)
        begin
            if (va < LOW_MARK)
                fa = '0;
            else if (vb < LOW_MARK)
                fb = '0;
        end
        sum     = (LVL_W + 1)'(fa) + (LVL_W + 1)'(fb);
        sum_adj = sum + $signed({{LVL_W{1'b0}}, sum[LVL_W]});
        if (fa != '0 && fb != '0)
            fused = LVL_W'(sum_adj >>> 1);
        else if (fa != '0)
            fused = fa;
        else
            fused = fb;
    end

    // trend classification over the raw history
    always_comb
    begin
        full = fill_reg > HISTORY_DEPTH;
        fill_next = full ? fill_reg : fill_reg + FILL_W'(1);
        c1 = full ? CHG_W'(height_a) - CHG_W'(hist_a_reg[HIST_TAPS-1]) : '0;
        c2 = full ? CHG_W'(height_b) - CHG_W'(hist_b_reg[HIST_TAPS-1]) : '0;
        dc = (CHG_W + 1)'(c1) - (CHG_W + 1)'(c2);

        rise_next  = rise_reg;
        fall_next  = fall_reg;
        still_next = still_reg;
        lag_next   = lag_reg;
        trend_next = trend_reg;

        if (c1 > RISE_LIM && c2 > RISE_LIM)
        begin
            rise_next  = rise_reg + CNT_W'(1);
            fall_next  = '0;
            lag_next   = '0;
            still_next = '0;
            if (rise_next > CONFIRM_TICKS)
            begin
                rise_next  = '0;
                trend_next = TR_RISE;
            end
        end
        else if (c1 < FALL_LIM && c2 < FALL_LIM)
        begin
            fall_next = fall_reg + CNT_W'(1);
            rise_next = '0;
            lag_next  = '0;
            if (c1 > RISE_LIM || c1 < -RISE_LIM || c2 > RISE_LIM || c2 < -RISE_LIM)
                still_next = '0;
            if (fall_next > CONFIRM_TICKS)
            begin
                still_next = '0;
                fall_next  = '0;
                trend_next = TR_FALL;
            end
        end
        else if (c1 < STILL_LIM && c1 > -STILL_LIM && c2 < STILL_LIM && c2 > -STILL_LIM)
        begin
            still_next = still_reg + CNT_W'(1);
            rise_next  = '0;
            fall_next  = '0;
            lag_next   = '0;
            if (still_next > 2 * CONFIRM_TICKS)
            begin
                still_next = '0;
                trend_next = TR_STILL;
            end
        end
        else
        begin
            rise_next  = '0;
            fall_next  = '0;
            still_next = '0;
            if (dc > LAG_LIM || dc < -LAG_LIM)
            begin
                lag_next   = LAG_W'(CONFIRM_TICKS);
                trend_next = TR_LAG;
            end
            else if (lag_reg != '0)
            begin
                lag_next   = lag_reg - LAG_W'(1);
                trend_next = TR_LAG;
            end
            else
            begin
                trend_next = TR_WAVE;
            end
        end
    end

    assign item.fused = fused;
    assign item.trend = trend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mismatch_reg <= '0;
            fill_reg     <= '0;
            rise_reg     <= '0;
            fall_reg     <= '0;
            still_reg    <= '0;
            lag_reg      <= '0;
            trend_reg    <= TR_WAVE;
        end
        else if (push)
        begin
            mismatch_reg <= mismatch_next;
            fill_reg     <= fill_next;
            rise_reg     <= rise_next;
            fall_reg     <= fall_next;
            still_reg    <= still_next;
            lag_reg      <= lag_next;
            trend_reg    <= trend_next;
        end
    end

    // oldest tap holds the sample taken HIST_TAPS requests ago
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            hist_a_reg[0] <= height_a;
            hist_b_reg[0] <= height_b;
            for (int i = 1; i < HIST_TAPS; i++)
            begin
                hist_a_reg[i] <= hist_a_reg[i-1];
                hist_b_reg[i] <= hist_b_reg[i-1];
            end
        end
    end

endmodule

// ===== rtl/core/dlfts_queue.sv =====
// ----------------------------------------------------------------------------
// dlfts_queue - short request queue
// Holds classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module dlfts_queue
    import dlfts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  dlfts_item_t push_item,
    output logic        ready,
    input  logic        pop,
    output logic        head_valid,
    output dlfts_item_t head_item
);

    dlfts_item_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign ready      = cnt_reg != QCNT_W'(QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_item  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + QPTR_W'(1);
        if (pop)
            rd_next = (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + QPTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule

// ===== rtl/core/dlfts_back.sv =====
// ----------------------------------------------------------------------------
// dlfts_back - leaky integrators and output selection
// Three stages: integrator update, mean divide, trend select into the
// output register.
// ----------------------------------------------------------------------------
module dlfts_back
    import dlfts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  dlfts_item_t      head_item,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    // integrator state
    logic signed [LONG_W-1:0]  long_reg, long_next;
    logic signed [SHORT_W-1:0] short_reg, short_next;
    logic [WARM_W-1:0]         warm_reg, warm_next;

    // stage 1
    logic                      s1_v_reg;
    logic signed [LONG_W-1:0]  s1_long_reg;
    logic signed [SHORT_W-1:0] s1_short_reg;
    logic [TR_W-1:0]           s1_trend_reg;
    logic signed [LVL_W-1:0]   s1_fused_reg;
    logic                      s1_direct_reg, direct;
    logic signed [LVL_W-1:0]   s1_dval_reg, dval;
    logic                      s1_warmed_reg;

    // stage 2
    logic                      s2_v_reg;
    logic signed [MEAN_W-1:0]  s2_m30_reg;
    logic signed [MEAN_W-1:0]  s2_m5_reg;
    logic [TR_W-1:0]           s2_trend_reg;
    logic signed [LVL_W-1:0]   s2_fused_reg;
    logic                      s2_direct_reg;
    logic signed [LVL_W-1:0]   s2_dval_reg;
    logic                      s2_warmed_reg;

    // output
    logic                      out_v_reg;
    logic [OUT_W-1:0]          out_reg;

    logic                      ready1, ready2, ready3;
    logic signed [BLEND_W-1:0] blend_in;
    logic signed [MEAN_W-1:0]  sel;
    logic signed [LVL_W-1:0]   smoothed;

    assign ready3 = !out_v_reg || m_tready;
    assign ready2 = !s2_v_reg || ready3;
    assign ready1 = !s1_v_reg || ready2;
    assign pop    = head_valid && ready1;

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    // integrator update
    always_comb
    begin
        long_next  = long_reg;
        short_next = short_reg;
        warm_next  = warm_reg;
        direct     = 1'b0;
        dval       = '0;
        if (warm_reg < WARM_W'(LONG_WINDOW))
        begin
            direct = 1'b1;
            // zero samples are skipped during warm-up
            if (head_item.fused != '0)
            begin
                dval      = head_item.fused;
                long_next = long_reg + LONG_W'(head_item.fused);
                if (warm_reg < WARM_W'(SHORT_WINDOW))
                    short_next = short_reg + SHORT_W'(head_item.fused);
                else
                    short_next = short_reg + SHORT_W'(head_item.fused)
                                 - SHORT_W'(div_short(short_reg));
                warm_next = warm_reg + WARM_W'(1);
            end
        end
        else
        begin
            long_next  = long_reg + LONG_W'(head_item.fused) - LONG_W'(div_long(long_reg));
            short_next = short_reg + SHORT_W'(head_item.fused)
                         - SHORT_W'(div_short(short_reg));
        end
    end

    // trend select
    always_comb
    begin
        blend_in = (BLEND_W'(s2_m5_reg) <<< 1) + BLEND_W'(s2_m30_reg);
        unique case (s2_trend_reg)
            TR_WAVE, TR_LAG: sel = s2_m30_reg;
            TR_STILL:        sel = div_blend(blend_in);
            default:         sel = s2_m5_reg;
        endcase
        smoothed = s2_direct_reg ? s2_dval_reg : LVL_W'(sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg  <= '0;
            short_reg <= '0;
            warm_reg  <= '0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                long_reg  <= long_next;
                short_reg <= short_next;
                warm_reg  <= warm_next;
            end
            if (ready1)
                s1_v_reg <= pop;
            if (ready2)
                s2_v_reg <= s1_v_reg;
            if (ready3)
                out_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            s1_long_reg   <= long_next;
            s1_short_reg  <= short_next;
            s1_trend_reg  <= head_item.trend;
            s1_fused_reg  <= head_item.fused;
            s1_direct_reg <= direct;
            s1_dval_reg   <= dval;
            s1_warmed_reg <= warm_next >= WARM_W'(LONG_WINDOW);
        end
        if (ready2)
        begin
            s2_m30_reg    <= div_long(s1_long_reg);
            s2_m5_reg     <= div_short(s1_short_reg);
            s2_trend_reg  <= s1_trend_reg;
            s2_fused_reg  <= s1_fused_reg;
            s2_direct_reg <= s1_direct_reg;
            s2_dval_reg   <= s1_dval_reg;
            s2_warmed_reg <= s1_warmed_reg;
        end
        if (ready3)
            out_reg <= {{(OUT_W - 2 * LVL_W - TR_W - 1){1'b0}}, s2_warmed_reg,
                        s2_trend_reg, s2_fused_reg, smoothed};
    end

endmodule

// ===== rtl/core/dual_level_fusion_trend_smoother.sv =====
// ----------------------------------------------------------------------------
// dual_level_fusion_trend_smoother - two-sensor level fusion and smoother
// Fuses two level-sensor heights, classifies the trend and outputs a
// trend-selected smoothed level.
//
//   channel   dir  payload (lowest bit first)
//   s_t*      in   height_a[15:0], height_b[31:16]
//   m_t*      out  smoothed_level[14:0], fused_level[29:15],
//                  trend_state[32:30], warmed_up[33], zero[39:34]
//
// One request per cycle while the output is not stalled; a request passes
// the queue, the integrator and mean divide registers and the select into
// the output register. The integrator is the back part's only feedback loop.
// A four-entry queue lets the front keep taking requests while the output
// is stalled. Reset clears counters and integrators; no clearing pass.
// ----------------------------------------------------------------------------
module dual_level_fusion_trend_smoother
    import dlfts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // height_a, height_b
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // smoothed_level, fused_level, trend_state, warmed_up
);

    logic        q_ready, push, pop, head_valid;
    dlfts_item_t push_item, head_item;

    assign s_tready = q_ready;

    dlfts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .q_ready  (q_ready),
        .height_a ($signed(s_tdata[15:0])),
        .height_b ($signed(s_tdata[31:16])),
        .push     (push),
        .item     (push_item)
    );

    dlfts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    dlfts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
